// ----- rtl/skyline_dominance_table_defines.svh -----
// assertion macros for the skyline dominance table
`ifndef SKYLINE_DOMINANCE_TABLE_DEFINES_SVH
`define SKYLINE_DOMINANCE_TABLE_DEFINES_SVH
// implication checked on every edge outside reset
`define SDT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/sdt_pkg.sv -----
// shared types and constants for the skyline dominance table
`timescale 1ns / 1ps
package sdt_pkg;
    localparam int TABLE_SLOTS  = 16;
    localparam int MAX_KEYWORDS = 8;
    localparam int DIST_BITS    = 16;
    localparam int NODE_BITS    = 31;
    localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
    localparam int CNT_BITS     = $clog2(TABLE_SLOTS + 1);
    localparam int KC_BITS      = 4;

    localparam logic [1:0] FUNC_OFFER = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [2:0] ST_REJECTED = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_ENTRY    = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    typedef logic [DIST_BITS-1:0] dist_t;
    typedef dist_t [MAX_KEYWORDS-1:0] vec_t;

    // record moving along the chain
    typedef struct packed {
        logic                 valid;
        logic [NODE_BITS-1:0] node;
        vec_t                 dvec;
    } entry_t;

    // per-step command from the controller to every cell
    typedef struct packed {
        logic shift;   // rotate the chain by one cell
        logic clear;   // invalidate every cell
        logic insert;  // replace the record entering the head cell
    } cell_ctl_t;
endpackage

// ----- rtl/sdt_cell.sv -----
// one slot of the table, rotating its record to the next cell
`timescale 1ns / 1ps
module sdt_cell
    import sdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  entry_t    prev,
    output entry_t    cur
);
    logic   valid_reg;
    entry_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= prev;
        end
    end

    always_comb
    begin
        cur       = data_reg;
        cur.valid = valid_reg;
    end
endmodule

// ----- rtl/skyline_dominance_table.sv -----
// top level: controller and rotating chain of slot cells
//
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall | func, node_id, dist_0..dist_7
//  out     | output    | out_valid/out_stall | status, entry_node, out_0..7, entry_count, last
//  cfg     | input     | cfg_we            | cfg_data (keyword_count)
//
// the table is a ring of TABLE_SLOTS cells; cell 0 is the head, and each pass
// rotates it once. an offer takes two passes (removals and duplicate check,
// then placement) and then a result that waits for a free output register.
// a read takes one pass, its results leaving one per rotation step while the
// output register is free; out_stall holds the rotation. a clear or a read of
// an empty table answers the cycle after acceptance.
// reset empties the table and sets keyword_count to 8.
`timescale 1ns / 1ps
module skyline_dominance_table
    import sdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [3:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           func,
    input  logic [30:0]          node_id,
    input  logic [15:0]          dist_0,
    input  logic [15:0]          dist_1,
    input  logic [15:0]          dist_2,
    input  logic [15:0]          dist_3,
    input  logic [15:0]          dist_4,
    input  logic [15:0]          dist_5,
    input  logic [15:0]          dist_6,
    input  logic [15:0]          dist_7,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [30:0]          entry_node,
    output logic [15:0]          out_0,
    output logic [15:0]          out_1,
    output logic [15:0]          out_2,
    output logic [15:0]          out_3,
    output logic [15:0]          out_4,
    output logic [15:0]          out_5,
    output logic [15:0]          out_6,
    output logic [15:0]          out_7,
    output logic [4:0]           entry_count,
    output logic                 last
);
`include "skyline_dominance_table_defines.svh"

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_PLACE, S_READ, S_RESP} state_t;

    state_t               state_reg;
    logic [KC_BITS-1:0]   kc_reg;
    logic [SLOT_BITS:0]   step_reg;
    logic                 stop_reg;      // equal record seen: no more removals
    logic                 reject_reg;
    logic                 dup_reg;
    logic                 placed_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  emitted_reg;
    logic [NODE_BITS-1:0] cand_node_reg;
    vec_t                 cand_reg;
    logic                 out_valid_reg;
    logic [2:0]           status_reg;
    entry_t               out_entry_reg;
    logic [CNT_BITS-1:0]  out_cnt_reg;
    logic                 last_reg;

    cell_ctl_t ctl;
    entry_t    chain [TABLE_SLOTS];
    entry_t    head_in;
    entry_t    tail;

    assign tail = chain[TABLE_SLOTS-1];

    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                sdt_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl),
                                 .prev(head_in), .cur(chain[g]));
            end
            else
            begin : g_body
                sdt_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl),
                                 .prev(chain[g-1]), .cur(chain[g]));
            end
        end
    endgenerate

    // compare candidate against the record leaving the tail
    logic smaller, larger, equal;
    always_comb
    begin
        smaller = 1'b1;
        larger  = 1'b1;
        equal   = 1'b1;
        for (int j = 0; j < MAX_KEYWORDS; j++)
        begin
            if (KC_BITS'(j) < kc_reg)
            begin
                if (cand_reg[j] > tail.dvec[j]) smaller = 1'b0;
                if (cand_reg[j] < tail.dvec[j]) larger  = 1'b0;
                if (cand_reg[j] != tail.dvec[j]) equal  = 1'b0;
            end
        end
    end

    logic [CNT_BITS-1:0] live_cnt;
    always_comb
    begin
        live_cnt = '0;
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            live_cnt = live_cnt + CNT_BITS'(chain[s].valid);
        end
    end

    logic out_free, accept_in;
    logic scan_kill, read_emit, load_out;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign accept_in = in_valid && !in_stall;
    assign scan_kill = (state_reg == S_SCAN) && tail.valid && !stop_reg && !reject_reg
                       && !equal && smaller;
    assign read_emit = (state_reg == S_READ) && tail.valid && out_free;
    assign load_out  = ((state_reg == S_IDLE) && accept_in
                        && ((func == FUNC_CLEAR) || ((func == FUNC_READ) && (live_cnt == '0))))
                       || ((state_reg == S_RESP) && out_free) || read_emit;

    // the rotation feeds the tail record back into the head
    always_comb
    begin
        ctl       = '0;
        head_in   = tail;
        ctl.clear = accept_in && (func == FUNC_CLEAR);
        unique case (state_reg)
            S_SCAN:  ctl.shift = 1'b1;
            S_PLACE: ctl.shift = 1'b1;
            S_READ:  ctl.shift = out_free;
            default: ctl.shift = 1'b0;
        endcase
        if (scan_kill)
        begin
            head_in.valid = 1'b0;
        end
        if ((state_reg == S_PLACE) && !tail.valid && !placed_reg && !dup_reg && !reject_reg)
        begin
            ctl.insert    = 1'b1;
            head_in.valid = 1'b1;
            head_in.node  = cand_node_reg;
            head_in.dvec  = cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kc_reg        <= KC_BITS'(MAX_KEYWORDS);
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            stop_reg      <= 1'b0;
            reject_reg    <= 1'b0;
            dup_reg       <= 1'b0;
            placed_reg    <= 1'b0;
            emitted_reg   <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                kc_reg <= (cfg_data > KC_BITS'(MAX_KEYWORDS)) ? KC_BITS'(MAX_KEYWORDS)
                                                              : cfg_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        step_reg    <= '0;
                        stop_reg    <= 1'b0;
                        reject_reg  <= 1'b0;
                        dup_reg     <= 1'b0;
                        placed_reg  <= 1'b0;
                        emitted_reg <= '0;
                        cnt_reg     <= live_cnt;
                        cand_node_reg <= node_id;
                        cand_reg <= {dist_7, dist_6, dist_5, dist_4,
                                     dist_3, dist_2, dist_1, dist_0};
                        case (func)
                            FUNC_OFFER: state_reg <= S_SCAN;
                            FUNC_READ:
                            begin
                                if (live_cnt == '0)
                                begin
                                    status_reg    <= ST_EMPTY;
                                    out_entry_reg <= '0;
                                    out_cnt_reg   <= '0;
                                    last_reg      <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                            FUNC_CLEAR:
                            begin
                                status_reg    <= ST_CLEARED;
                                out_entry_reg <= '0;
                                out_cnt_reg   <= '0;
                                last_reg      <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (tail.valid && !stop_reg && !reject_reg)
                    begin
                        if (equal)
                            stop_reg <= 1'b1;
                        else if (!smaller && larger)
                            reject_reg <= 1'b1;
                    end
                    // a surviving record with the same node id blocks the insert
                    if (tail.valid && !scan_kill && tail.node == cand_node_reg)
                        dup_reg <= 1'b1;
                    if (step_reg == (SLOT_BITS+1)'(TABLE_SLOTS - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= S_PLACE;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_PLACE:
                begin
                    // first free slot in one rotation
                    if (ctl.insert)
                        placed_reg <= 1'b1;
                    if (step_reg == (SLOT_BITS+1)'(TABLE_SLOTS - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_entry_reg <= '0;
                        out_cnt_reg   <= live_cnt;
                        last_reg      <= 1'b1;
                        if (reject_reg)
                            status_reg <= ST_REJECTED;
                        else if (dup_reg || placed_reg)
                            status_reg <= ST_ACCEPTED;
                        else
                            status_reg <= ST_DROPPED;
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        if (tail.valid)
                        begin
                            status_reg    <= ST_ENTRY;
                            out_entry_reg <= tail;
                            out_cnt_reg   <= cnt_reg;
                            last_reg      <= (emitted_reg + 1'b1) == cnt_reg;
                            emitted_reg   <= emitted_reg + 1'b1;
                        end
                        if (step_reg == (SLOT_BITS+1)'(TABLE_SLOTS - 1))
                        begin
                            step_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_node  = out_entry_reg.node;
    assign out_0       = out_entry_reg.dvec[0];
    assign out_1       = out_entry_reg.dvec[1];
    assign out_2       = out_entry_reg.dvec[2];
    assign out_3       = out_entry_reg.dvec[3];
    assign out_4       = out_entry_reg.dvec[4];
    assign out_5       = out_entry_reg.dvec[5];
    assign out_6       = out_entry_reg.dvec[6];
    assign out_7       = out_entry_reg.dvec[7];
    assign entry_count = out_cnt_reg;
    assign last        = last_reg;

    `SDT_ASSERT_IMP(a_no_insert_on_reject, clk, rst_n, ctl.insert, !reject_reg && !dup_reg,
                    "insert after reject or duplicate")
    `SDT_ASSERT_IMP(a_kc_range, clk, rst_n, 1'b1, kc_reg <= KC_BITS'(MAX_KEYWORDS),
                    "keyword count out of range")
    `SDT_ASSERT_NEXT(a_read_emit, clk, rst_n, read_emit, out_valid_reg && status_reg == ST_ENTRY,
                     "read entry not presented")
endmodule
